// ----- hdl/snr_pkg.sv -----
`default_nettype none

package snr_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int OCC_W = 16;
    localparam int TUSER_W = 2;

    localparam int TUSER_BYTE_VALID = 0;
    localparam int TUSER_TEXT_END = 1;

    localparam logic [OCC_W-1:0] OCC_SAT = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES     = 3'd0,
        REG_PATTERN_LEN       = 3'd1,
        REG_REPLACEMENT_BYTES = 3'd2,
        REG_REPLACEMENT_LEN   = 3'd3,
        REG_OCCURRENCE_SELECT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [63:0]      pattern_bytes;
        logic [3:0]       pattern_len;
        logic [63:0]      replacement_bytes;
        logic [3:0]       replacement_len;
        logic [OCC_W-1:0] occurrence_select;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pattern_bytes:     64'd0,
        pattern_len:       4'd1,
        replacement_bytes: 64'd0,
        replacement_len:   4'd0,
        occurrence_select: 16'd0
    };

endpackage

`default_nettype wire

// ----- hdl/snr_front.sv -----
`default_nettype none

module snr_front #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8,
    localparam int WIN_N = PATTERN_MAX + 1,
    localparam int REC_N = (WIN_N > REPLACE_MAX) ? WIN_N : REPLACE_MAX,
    localparam int CNT_W = $clog2(REC_N + 1),
    localparam int REC_W = 1 + CNT_W + 8 * REC_N
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire snr_pkg::cfg_t    cfg,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tlast,
    output logic                  rec_valid,
    input  wire logic             rec_ready,
    output logic [REC_W-1:0]      rec_data
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);

    logic [7:0]               win_reg [PATTERN_MAX];
    logic [7:0]               win_next [PATTERN_MAX];
    logic [7:0]               win_shift [PATTERN_MAX];
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [snr_pkg::OCC_W-1:0] occ_reg, occ_next, occ_inc;

    logic [7:0]               w [REC_N];
    logic [7:0]               rec_bytes [REC_N];
    logic [WIN_N-1:0]         ok;
    logic [CNT_W-1:0]         n, pops, plen_c, rlen_c, count;
    logic [3:0]               plen_eff, rlen_eff;
    logic                     match, sel, accept, flush;

    always_comb begin
        if (cfg.pattern_len == 4'd0) begin
            plen_eff = 4'd1;
        end else if (cfg.pattern_len > 4'(PATTERN_MAX)) begin
            plen_eff = 4'(PATTERN_MAX);
        end else begin
            plen_eff = cfg.pattern_len;
        end
        if (cfg.replacement_len > 4'(REPLACE_MAX)) begin
            rlen_eff = 4'(REPLACE_MAX);
        end else begin
            rlen_eff = cfg.replacement_len;
        end
        plen_c = CNT_W'(plen_eff);
        rlen_c = CNT_W'(rlen_eff);
    end

    always_comb begin
        for (int i = 0; i < REC_N; i++) begin
            w[i] = s_tdata;
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (FILL_W'(i) < fill_reg) begin
                w[i] = win_reg[i];
            end
        end
        n = CNT_W'(fill_reg) + CNT_W'(1);
    end

    // test every suffix of the extended window against the pattern head
    always_comb begin
        logic [CNT_W-1:0] len_s;
        for (int s = 0; s < WIN_N; s++) begin
            len_s = n - CNT_W'(s);
            ok[s] = (CNT_W'(s) < n) && (len_s <= plen_c);
            for (int j = 0; j < PATTERN_MAX && s + j < WIN_N; j++) begin
                if (CNT_W'(j) < len_s && w[s+j] != cfg.pattern_bytes[8*j +: 8]) begin
                    ok[s] = 1'b0;
                end
            end
        end
        pops = n;
        for (int s = WIN_N - 1; s >= 0; s--) begin
            if (ok[s]) begin
                pops = CNT_W'(s);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_shift[i] = w[i];
        end
        for (int s = 1; s < WIN_N; s++) begin
            if (pops == CNT_W'(s)) begin
                for (int i = 0; i < PATTERN_MAX && s + i < REC_N; i++) begin
                    win_shift[i] = w[s+i];
                end
            end
        end
    end

    always_comb begin
        match = (pops == '0) && (n == plen_c);
        occ_inc = (occ_reg == snr_pkg::OCC_SAT) ? occ_reg : occ_reg + 1'b1;
        sel = (cfg.occurrence_select == '0) ||
              ((occ_reg != snr_pkg::OCC_SAT) && (occ_inc == cfg.occurrence_select));
        flush = match || s_tlast;

        for (int i = 0; i < REC_N; i++) begin
            rec_bytes[i] = w[i];
        end
        if (match && sel) begin
            for (int i = 0; i < REC_N; i++) begin
                rec_bytes[i] = 8'd0;
            end
            for (int i = 0; i < REPLACE_MAX; i++) begin
                rec_bytes[i] = cfg.replacement_bytes[8*i +: 8];
            end
            count = rlen_c;
        end else if (flush) begin
            count = n;
        end else begin
            count = pops;
        end

        for (int i = 0; i < REC_N; i++) begin
            rec_data[8*i +: 8] = rec_bytes[i];
        end
        rec_data[8*REC_N +: CNT_W] = count;
        rec_data[REC_W-1] = s_tlast;
    end

    assign s_tready  = rec_ready;
    assign accept    = s_tvalid && s_tready;
    assign rec_valid = s_tvalid && ((count != '0) || s_tlast);

    always_comb begin
        fill_next = fill_reg;
        occ_next  = occ_reg;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_next[i] = win_reg[i];
        end
        if (accept) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                win_next[i] = win_shift[i];
            end
            fill_next = flush ? '0 : FILL_W'(n - pops);
            if (s_tlast) begin
                occ_next = '0;
            end else if (match) begin
                occ_next = occ_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            occ_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/snr_queue.sv -----
`default_nettype none

module snr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/snr_back.sv -----
`default_nettype none

module snr_back #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8,
    localparam int WIN_N = PATTERN_MAX + 1,
    localparam int REC_N = (WIN_N > REPLACE_MAX) ? WIN_N : REPLACE_MAX,
    localparam int CNT_W = $clog2(REC_N + 1),
    localparam int REC_W = 1 + CNT_W + 8 * REC_N
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rec_valid,
    output logic                               rec_pop,
    input  wire logic [REC_W-1:0]              rec_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // out_byte
    output logic [snr_pkg::TUSER_W-1:0]        m_tuser,   // byte_valid, text_end
    output logic                               m_tlast    // run_last
);

    logic [CNT_W-1:0] idx_reg, idx_next, count;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next, cur_byte;
    logic [snr_pkg::TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic             m_tlast_reg, m_tlast_next;
    logic             load, rec_last, run_last, byte_valid;

    assign count    = rec_data[8*REC_N +: CNT_W];
    assign rec_last = rec_data[REC_W-1];

    always_comb begin
        cur_byte = 8'd0;
        for (int i = 0; i < REC_N; i++) begin
            if (idx_reg == CNT_W'(i)) begin
                cur_byte = rec_data[8*i +: 8];
            end
        end
        byte_valid = (count != '0);
        run_last   = !byte_valid || (idx_reg + 1'b1 == count);
        load       = !m_tvalid_reg || m_tready;
        rec_pop    = load && rec_valid && run_last;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        idx_next      = idx_reg;
        if (load) begin
            m_tvalid_next = rec_valid;
            m_tdata_next  = byte_valid ? cur_byte : 8'd0;
            m_tuser_next[snr_pkg::TUSER_BYTE_VALID] = byte_valid;
            m_tuser_next[snr_pkg::TUSER_TEXT_END]   = rec_last && run_last;
            m_tlast_next  = run_last;
            if (rec_valid) begin
                idx_next = run_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- hdl/stream_search_replace.sv -----
// Streaming search and replace, one text byte per transaction.
// s_ channel: s_tdata is the text byte, s_tlast marks the final byte of a text.
// m_ channel: m_tdata is an output byte, m_tuser[0] says the byte is real,
// m_tuser[1] marks the final transaction of the text, m_tlast closes the
// group of transactions caused by one input byte. A last input byte that
// leaves nothing to send yields one marker transaction with m_tuser[0] low.
// Configure through cfg_we/cfg_index/cfg_data only while the block is idle:
// 0 pattern bytes, 1 pattern length, 2 replacement bytes, 3 replacement
// length, 4 occurrence select (0 replaces all).
// An accepted byte is registered in the queue and then in the output register.
// Throughput: one input byte per cycle while each byte causes at most one
// output byte and m_tready is high; a byte that releases k bytes holds the
// output while the single output register drains one byte per cycle. A
// two-entry queue separates matching from output; s_tready falls when it is
// full, so a stalled receiver stops the input after at most three pending
// groups, two in the queue and one in the output register.
// Reset clears the window, the occurrence count, the queue and the output,
// and returns the registers to their defaults (pattern length 1).
`default_nettype none

module stream_search_replace #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [snr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [snr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // data_byte
    input  wire logic                               s_tlast,   // is_last
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // out_byte
    output logic [snr_pkg::TUSER_W-1:0]             m_tuser,   // byte_valid, text_end
    output logic                                    m_tlast    // run_last
);

    localparam int WIN_N = PATTERN_MAX + 1;
    localparam int REC_N = (WIN_N > REPLACE_MAX) ? WIN_N : REPLACE_MAX;
    localparam int CNT_W = $clog2(REC_N + 1);
    localparam int REC_W = 1 + CNT_W + 8 * REC_N;
    localparam int QUEUE_DEPTH = 2;

    snr_pkg::cfg_t    cfg_reg, cfg_next;
    logic             push_valid, push_ready, pop_valid, pop;
    logic [REC_W-1:0] push_data, pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                snr_pkg::REG_PATTERN_BYTES:     cfg_next.pattern_bytes = cfg_data;
                snr_pkg::REG_PATTERN_LEN:       cfg_next.pattern_len = cfg_data[3:0];
                snr_pkg::REG_REPLACEMENT_BYTES: cfg_next.replacement_bytes = cfg_data;
                snr_pkg::REG_REPLACEMENT_LEN:   cfg_next.replacement_len = cfg_data[3:0];
                snr_pkg::REG_OCCURRENCE_SELECT: begin
                    cfg_next.occurrence_select = cfg_data[snr_pkg::OCC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= snr_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    snr_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .rec_valid (push_valid),
        .rec_ready (push_ready),
        .rec_data  (push_data)
    );

    snr_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    snr_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (pop_valid),
        .rec_pop   (pop),
        .rec_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/snr_checker.sv -----
`default_nettype none

module snr_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [7:0]                      m_tdata,
    input wire logic [snr_pkg::TUSER_W-1:0]     m_tuser,
    input wire logic                            m_tlast
);

    // hold a stalled result transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[snr_pkg::TUSER_BYTE_VALID] |->
            m_tlast && m_tuser[snr_pkg::TUSER_TEXT_END] && m_tdata == 8'd0)
        else $error("end marker without end flags or with data");

    a_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[snr_pkg::TUSER_TEXT_END] |-> m_tlast)
        else $error("text end inside a run");

    a_reset_clears: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind stream_search_replace snr_checker u_snr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
